[rtl/shrp_pkg.sv]
// ----------------------------------------------------------------------------
// shrp_pkg
// Shared constants and types for the 3x3 sharpening stream filter.
// ----------------------------------------------------------------------------
package shrp_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_WIDTH    = 2048;
  localparam int DEF_MAX_CHANNELS = 4;

  // fixed field widths
  localparam int PIX_W     = 8;   // one channel byte
  localparam int CFG_W     = 12;  // widest config register
  localparam int REG_IDX_W = 2;   // config register index
  localparam int ROW_W     = 12;  // row counter, holds 0..HEIGHT_LIMIT+1
  localparam int CH_W      = 3;   // channel count register

  localparam int MIN_DIM      = 3;
  localparam int HEIGHT_LIMIT = 2048;
  localparam int SHARP_GAIN   = 5;  // center tap weight

  // config register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  // per-word position info, control -> datapath
  typedef struct packed {
    logic produce;  // word yields a result (row > 0)
    logic border;   // result is forced to zero
    logic eof;      // last result of the frame
  } item_flags_t;

endpackage

[rtl/sharpen_3x3_stream.sv]
// ----------------------------------------------------------------------------
// sharpen_3x3_stream
// Pipeline: an accepted word passes the read stage (line store read) and
//   then the result register; results lag by one row.
// Throughput: one word per clock; the input stalls only while a result is
//   held by m_tready low and stage 1 holds a word that yields a result.
// Reset: clears position counters and pipeline valids, config returns to
//   640 x 480 x 3; line stores are not cleared.
// ----------------------------------------------------------------------------
//
// Streaming 3x3 sharpen, kernel 0,-1,0 / -1,5,-1 / 0,-1,0, over interleaved
// channel bytes in raster order. Each result is 5*center minus the up, down,
// left and right bytes of the same channel (left/right are channel_count
// bytes away), clamped to 0..255; border pixels give 0.
//
// Two line stores hold the previous two rows. Each word reads above[col]
// (up), center[col] (center) and center[col+ch] (right, from a second copy
// of the center store), then writes center -> above and the new byte ->
// center. The left neighbor comes from a short delay line of center bytes.
//
// Framing is positional: input row 0 yields no results, and one row of
// drain words must follow each frame to flush the last result row. The
// drain flag itself is not looked at; drain samples are taken as zero.
//
// Config (cfg_index): 0 frame_width, 1 frame_height, 2 channel_count.
// Values are clamped to width 3..MAX_WIDTH, height 3..2048, channels
// 1..MAX_CHANNELS. Write only while the pipeline is empty.
// ----------------------------------------------------------------------------
module sharpen_3x3_stream #(
  parameter int MAX_WIDTH    = shrp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = shrp_pkg::DEF_MAX_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] sample
  input  logic                           s_tuser,   // [0] drain
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] value
  output logic                           m_tlast,   // end_of_frame
  // config write port
  input  logic                           cfg_wr_en,
  input  logic [shrp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [shrp_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int Depth = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = $clog2(Depth);

  logic                       accept;
  logic [AW-1:0]              rd_col;
  logic [AW-1:0]              rd_right;
  logic [shrp_pkg::PIX_W-1:0] sample_eff;
  shrp_pkg::item_flags_t      flags;
  logic [shrp_pkg::CH_W-1:0]  ch;

  logic [shrp_pkg::PIX_W-1:0] up;
  logic [shrp_pkg::PIX_W-1:0] mid;
  logic [shrp_pkg::PIX_W-1:0] right;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [shrp_pkg::PIX_W-1:0] above_wdata;
  logic [shrp_pkg::PIX_W-1:0] center_wdata;

  // position tracking and config
  shrp_ctrl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .sample     (s_tdata),
    .rd_col     (rd_col),
    .rd_right   (rd_right),
    .sample_eff (sample_eff),
    .flags      (flags),
    .ch         (ch)
  );

  // row two back
  shrp_ram #(
    .WIDTH (shrp_pkg::PIX_W),
    .DEPTH (Depth)
  ) u_above_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (above_wdata),
    .re    (accept),
    .raddr (rd_col),
    .rdata (up)
  );

  // previous row, read at the current column
  shrp_ram #(
    .WIDTH (shrp_pkg::PIX_W),
    .DEPTH (Depth)
  ) u_center_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (center_wdata),
    .re    (accept),
    .raddr (rd_col),
    .rdata (mid)
  );

  // copy of the previous row, read one pixel ahead for the right tap
  shrp_ram #(
    .WIDTH (shrp_pkg::PIX_W),
    .DEPTH (Depth)
  ) u_right_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (center_wdata),
    .re    (accept),
    .raddr (rd_right),
    .rdata (right)
  );

  // kernel math and output register
  shrp_core #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .accept       (accept),
    .sample_eff   (sample_eff),
    .flags        (flags),
    .col          (rd_col),
    .ch           (ch),
    .up           (up),
    .mid          (mid),
    .right        (right),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .above_wdata  (above_wdata),
    .center_wdata (center_wdata),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_value    (m_tdata),
    .out_last     (m_tlast)
  );

endmodule

[rtl/shrp_ram.sv]
// ----------------------------------------------------------------------------
// shrp_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module shrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/shrp_ctrl.sv]
// ----------------------------------------------------------------------------
// shrp_ctrl
// Config registers, column/row tracking, line store read addresses and
// border / end-of-frame flags for each accepted word.
// ----------------------------------------------------------------------------
module shrp_ctrl #(
  parameter int MAX_WIDTH    = shrp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = shrp_pkg::DEF_MAX_CHANNELS,
  localparam int Depth       = MAX_WIDTH * MAX_CHANNELS,
  localparam int AW          = $clog2(Depth)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [shrp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [shrp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           accept,
  input  logic [shrp_pkg::PIX_W-1:0]     sample,
  output logic [AW-1:0]                  rd_col,
  output logic [AW-1:0]                  rd_right,
  output logic [shrp_pkg::PIX_W-1:0]     sample_eff,
  output shrp_pkg::item_flags_t          flags,
  output logic [shrp_pkg::CH_W-1:0]      ch
);

  localparam int COL_W = $clog2(Depth + 1);

  logic [shrp_pkg::CFG_W-1:0] frame_width;
  logic [shrp_pkg::CFG_W-1:0] frame_height;
  logic [shrp_pkg::CH_W-1:0]  channel_count;

  logic [COL_W-1:0]          col_pos, col_pos_next;
  logic [shrp_pkg::ROW_W-1:0] row_pos, row_pos_next;

  logic [shrp_pkg::CFG_W-1:0] w_c;
  logic [shrp_pkg::ROW_W-1:0] h_c;
  logic [COL_W-1:0]          len;
  logic                      wrap_in;
  logic [COL_W-1:0]          col_eff;
  logic [COL_W-1:0]          col_inc;
  logic [COL_W:0]            right;
  logic [shrp_pkg::ROW_W-1:0] row_step;
  logic [shrp_pkg::ROW_W-1:0] row_eff;
  logic [shrp_pkg::ROW_W-1:0] row_inc;
  logic                      end_row;
  logic                      last_row;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= shrp_pkg::CFG_W'(640);
      frame_height  <= shrp_pkg::CFG_W'(480);
      channel_count <= shrp_pkg::CH_W'(3);
    end else if (cfg_wr_en) begin
      unique case (shrp_pkg::cfg_reg_t'(cfg_index))
        shrp_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_wdata;
        shrp_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_wdata;
        shrp_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_wdata[shrp_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp config to legal ranges
  always_comb begin
    if (frame_width < shrp_pkg::CFG_W'(shrp_pkg::MIN_DIM)) begin
      w_c = shrp_pkg::CFG_W'(shrp_pkg::MIN_DIM);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_c = shrp_pkg::CFG_W'(MAX_WIDTH);
    end else begin
      w_c = frame_width;
    end

    if (frame_height < shrp_pkg::CFG_W'(shrp_pkg::MIN_DIM)) begin
      h_c = shrp_pkg::ROW_W'(shrp_pkg::MIN_DIM);
    end else if (32'(frame_height) > shrp_pkg::HEIGHT_LIMIT) begin
      h_c = shrp_pkg::ROW_W'(shrp_pkg::HEIGHT_LIMIT);
    end else begin
      h_c = frame_height;
    end

    if (channel_count == '0) begin
      ch = shrp_pkg::CH_W'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      ch = shrp_pkg::CH_W'(MAX_CHANNELS);
    end else begin
      ch = channel_count;
    end
  end

  // position of the current word; a stale position past the row or frame
  // end (only after a config change) is folded back first
  always_comb begin
    len      = COL_W'(32'(w_c) * 32'(ch));
    wrap_in  = (col_pos >= len);
    col_eff  = wrap_in ? '0 : col_pos;
    row_step = wrap_in ? row_pos + 1'b1 : row_pos;
    row_eff  = (row_step > h_c) ? '0 : row_step;
    last_row = (row_eff == h_c);

    col_inc  = col_eff + 1'b1;
    right    = {1'b0, col_eff} + (COL_W + 1)'(ch);
    end_row  = (col_inc >= len);
    row_inc  = row_eff + 1'b1;

    col_pos_next = end_row ? '0 : col_inc;
    if (end_row) begin
      row_pos_next = (row_inc > h_c) ? '0 : row_inc;
    end else begin
      row_pos_next = row_eff;
    end

    flags.produce = (row_eff != '0);
    flags.border  = (row_eff == shrp_pkg::ROW_W'(1)) || last_row ||
                    (col_eff < COL_W'(ch)) || (right >= {1'b0, len});
    flags.eof     = last_row && (col_inc == len);

    rd_col     = col_eff[AW-1:0];
    rd_right   = right[AW-1:0];
    sample_eff = last_row ? '0 : sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

endmodule

[rtl/shrp_core.sv]
// ----------------------------------------------------------------------------
// shrp_core
// Read stage and result register: kernel sum, clamp, line store write-back,
// left-neighbor delay line and the output handshake.
// ----------------------------------------------------------------------------
module shrp_core #(
  parameter int MAX_WIDTH    = shrp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = shrp_pkg::DEF_MAX_CHANNELS,
  localparam int Depth       = MAX_WIDTH * MAX_CHANNELS,
  localparam int AW          = $clog2(Depth)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic                       accept,
  input  logic [shrp_pkg::PIX_W-1:0] sample_eff,
  input  shrp_pkg::item_flags_t      flags,
  input  logic [AW-1:0]              col,
  input  logic [shrp_pkg::CH_W-1:0]  ch,
  input  logic [shrp_pkg::PIX_W-1:0] up,
  input  logic [shrp_pkg::PIX_W-1:0] mid,
  input  logic [shrp_pkg::PIX_W-1:0] right,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [shrp_pkg::PIX_W-1:0] above_wdata,
  output logic [shrp_pkg::PIX_W-1:0] center_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [shrp_pkg::PIX_W-1:0] out_value,
  output logic                       out_last
);

  localparam int LI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W = shrp_pkg::PIX_W + 3;  // 5*255 fits

  logic                       s1_valid;
  shrp_pkg::item_flags_t      s1_flags;
  logic [shrp_pkg::PIX_W-1:0] s1_sample;
  logic [AW-1:0]              s1_col;
  logic                       s1_adv;

  logic [shrp_pkg::PIX_W-1:0] left_line [MAX_CHANNELS];
  logic [shrp_pkg::PIX_W-1:0] left;
  logic [shrp_pkg::CH_W-1:0]  ch_m1;

  logic [SUM_W-1:0]           pos_sum;
  logic [SUM_W-1:0]           neg_sum;
  logic [SUM_W-1:0]           diff;
  logic [shrp_pkg::PIX_W-1:0] value;

  function automatic logic [SUM_W-1:0] SHARP_GAIN_MUL(input logic [shrp_pkg::PIX_W-1:0] x);
    SHARP_GAIN_MUL = SUM_W'(x) * SUM_W'(shrp_pkg::SHARP_GAIN);
  endfunction

  // stage 1 frees up when its word needs no output slot or the slot is free or drains
  assign s1_adv   = s1_valid && (!s1_flags.produce || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags  <= flags;
      s1_sample <= sample_eff;
      s1_col    <= col;
    end
  end

  // line store rotation: center moves to above, new sample goes to center
  assign wr_en        = s1_adv;
  assign wr_addr      = s1_col;
  assign above_wdata  = mid;
  assign center_wdata = s1_sample;

  // left neighbor = center byte seen ch words earlier in this row
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_line[0] <= mid;
      for (int i = 1; i < MAX_CHANNELS; i++) begin
        left_line[i] <= left_line[i-1];
      end
    end
  end

  assign ch_m1 = ch - 1'b1;
  assign left  = left_line[ch_m1[LI_W-1:0]];

  // 5*mid - up - down - left - right, clamped to 0..255
  always_comb begin
    pos_sum = SUM_W'(SHARP_GAIN_MUL(mid));
    neg_sum = SUM_W'(up) + SUM_W'(s1_sample) + SUM_W'(left) + SUM_W'(right);
    diff    = pos_sum - neg_sum;
    if (s1_flags.border || (neg_sum > pos_sum)) begin
      value = '0;
    end else if (diff > SUM_W'(8'hFF)) begin
      value = '1;
    end else begin
      value = diff[shrp_pkg::PIX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_flags.produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags.produce) begin
      out_value <= value;
      out_last  <= s1_flags.eof;
    end
  end

endmodule

[rtl/shrp_checker.sv]
// ----------------------------------------------------------------------------
// shrp_checker
// Port-level checks for the sharpen stream, bound to the top level.
// ----------------------------------------------------------------------------
module shrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // input side never blocks while the result slot is free or draining
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled with a free result slot");

  // a fresh result traces back to an input word that passed the read stage and the result register
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result word without a matching input word");

  // last word of a frame sits on the bottom border
  a_eof_border: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == 8'd0)
    else $error("end-of-frame word not zero");

  // result register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sharpen_3x3_stream shrp_checker u_shrp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
